/* hdl/trapezoidal_velocity_profile_unit_macros.svh */
// assertion macros for the trapezoidal velocity profile unit
// expects clk_i and rst_ni in the scope of each use
`ifndef TRAPEZOIDAL_VELOCITY_PROFILE_UNIT_MACROS_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILE_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define TVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TVP_ASSERT_IMP(label, ante, cons, msg)

`define TVP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/tvp_pkg.sv */
// shared widths, register indexes, reset values and types of the profile unit
// no dependencies
package tvp_pkg;

  // field widths
  localparam int VelW          = 23;
  localparam int DistW         = 36;
  localparam int CovW          = 37;
  localparam int RateW         = 16;
  localparam int TickCountBits = 24;
  localparam int ElapsedW      = 24;

  // configuration port
  localparam int CfgW    = 36;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgStartVel  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxVel    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEndVel    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAccelRate = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDecelRate = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMoveDist  = 3'd5;

  // register reset values
  localparam logic [VelW-1:0]  StartVelRst  = 23'd0;
  localparam logic [VelW-1:0]  MaxVelRst    = 23'd4000000;
  localparam logic [VelW-1:0]  EndVelRst    = 23'd1000000;
  localparam logic [RateW-1:0] AccelRateRst = 16'd12000;
  localparam logic [RateW-1:0] DecelRateRst = 16'd12000;
  localparam logic [DistW-1:0] MoveDistRst  = 36'd0;

  localparam logic [VelW-1:0] VelMax = {VelW{1'b1}};

  // serial multiply: multiplicand and multiplier widths, product bits walked
  localparam int McandW      = 23;
  localparam int MplierW     = 37;
  localparam int SerialSteps = McandW + MplierW - 6;
  localparam int StepCntW    = $clog2(SerialSteps);

  // control shared by the serial multipliers and the serial comparator
  typedef struct packed {
    logic load;
    logic step;
  } tvp_ser_ctl_t;

endpackage

/* hdl/tvp_if.sv */
// valid/ready channels of the profile unit: tick input and profile output
// depends on tvp_pkg
interface tvp_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tvp_out_if import tvp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VelW-1:0]     velocity_now;
  logic [CovW-1:0]     travelled;
  logic [ElapsedW-1:0] elapsed_ticks;
  logic                braking;
  logic                finished;

  modport source (output valid, output velocity_now, output travelled,
                  output elapsed_ticks, output braking, output finished,
                  input ready);
  modport sink (input valid, input velocity_now, input travelled,
                input elapsed_ticks, input braking, input finished,
                output ready);
endinterface

/* hdl/trapezoidal_velocity_profile_unit.sv */
// Trapezoidal velocity profile unit: one input word per tick or restart,
// one output word with velocity, distance, tick count, phase and done flag.
// A tick in the accelerate phase runs the braking test: it walks 54 product
// bits of three bit-serial multipliers (v^2, ve^2 and (remaining+1)*2*decel)
// into a serial comparator, one bit per cycle, then applies the step and loads
// the output register once it is free. A restart, a tick after the move is
// done, and a decelerate-phase tick skip the serial walk. The output register
// holds a word until taken while the next input word is already accepted.
// Config registers are written directly, so a write during a tick can change its step.
// Depends on tvp_pkg, tvp_if, tvp_bit_mul, tvp_serial_cmp and the macro header.
`include "trapezoidal_velocity_profile_unit_macros.svh"

module trapezoidal_velocity_profile_unit import tvp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tvp_in_if.sink             in_ch,
  tvp_out_if.source          out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  localparam logic [StepCntW-1:0]      LastStep = StepCntW'(SerialSteps - 1);
  localparam logic [TickCountBits-1:0] TickMax  = {TickCountBits{1'b1}};

  // configuration registers
  logic [VelW-1:0]  start_vel_q, max_vel_q, end_vel_q;
  logic [RateW-1:0] accel_q, decel_q;
  logic [DistW-1:0] move_dist_q;

  // profile state
  logic [1:0]               state_q;
  logic [StepCntW-1:0]      cnt_q;
  logic [VelW-1:0]          speed_q;
  logic [CovW-1:0]          covered_q;
  logic [TickCountBits-1:0] tick_q;
  logic                     braking_q;

  // output register
  logic                out_valid_q;
  logic [VelW-1:0]     out_vel_q;
  logic [CovW-1:0]     out_cov_q;
  logic [ElapsedW-1:0] out_tick_q;
  logic                out_brake_q;
  logic                out_fin_q;

  logic               in_fire, out_fire, push_go, active;
  logic [MplierW-1:0] rem_plus1;
  logic [RateW-1:0]   rate_eff;
  logic [McandW-1:0]  lim_mcand;
  logic [VelW:0]      acc_sum;
  logic [VelW-1:0]    speed_next;
  logic [CovW-1:0]    cov_next;
  logic               v_sq_bit, ve_sq_bit, lim_bit, brake;
  tvp_ser_ctl_t       ser_ctl;

  // handshakes
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign push_go     = (state_q == S_PUSH) && (!out_valid_q || out_ch.ready);

  // move still running and braking-test operands
  always_comb begin
    active    = covered_q < CovW'(move_dist_q);
    rem_plus1 = MplierW'(move_dist_q) - MplierW'(covered_q) + MplierW'(1);
    rate_eff  = (decel_q == '0) ? RateW'(1) : decel_q;
    lim_mcand = McandW'({rate_eff, 1'b0});
  end

  assign ser_ctl.load = in_fire;
  assign ser_ctl.step = (state_q == S_CALC);

  // serial products and comparator
  tvp_bit_mul u_mul_v (
    .clk_i    (clk_i),
    .ctl_i    (ser_ctl),
    .mcand_i  (McandW'(speed_q)),
    .mplier_i (MplierW'(speed_q)),
    .bit_o    (v_sq_bit)
  );

  tvp_bit_mul u_mul_ve (
    .clk_i    (clk_i),
    .ctl_i    (ser_ctl),
    .mcand_i  (McandW'(end_vel_q)),
    .mplier_i (MplierW'(end_vel_q)),
    .bit_o    (ve_sq_bit)
  );

  tvp_bit_mul u_mul_lim (
    .clk_i    (clk_i),
    .ctl_i    (ser_ctl),
    .mcand_i  (lim_mcand),
    .mplier_i (rem_plus1),
    .bit_o    (lim_bit)
  );

  tvp_serial_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ser_ctl),
    .v_sq_i  (v_sq_bit),
    .ve_sq_i (ve_sq_bit),
    .lim_i   (lim_bit),
    .brake_o (brake)
  );

  // velocity step with clamps, then distance
  always_comb begin
    acc_sum = {1'b0, speed_q} + (VelW + 1)'(accel_q);
    if (!braking_q) begin
      if (speed_q >= max_vel_q) begin
        speed_next = max_vel_q;
      end else if (acc_sum[VelW]) begin
        speed_next = VelMax;
      end else begin
        speed_next = acc_sum[VelW-1:0];
      end
    end else begin
      if (speed_q <= end_vel_q) begin
        speed_next = end_vel_q;
      end else if (speed_q > VelW'(decel_q)) begin
        speed_next = speed_q - VelW'(decel_q);
      end else begin
        speed_next = '0;
      end
    end
    cov_next = covered_q + CovW'(speed_next);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_vel_q <= StartVelRst;
      max_vel_q   <= MaxVelRst;
      end_vel_q   <= EndVelRst;
      accel_q     <= AccelRateRst;
      decel_q     <= DecelRateRst;
      move_dist_q <= MoveDistRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStartVel:  start_vel_q <= cfg_data_i[VelW-1:0];
        CfgMaxVel:    max_vel_q   <= cfg_data_i[VelW-1:0];
        CfgEndVel:    end_vel_q   <= cfg_data_i[VelW-1:0];
        CfgAccelRate: accel_q     <= cfg_data_i[RateW-1:0];
        CfgDecelRate: decel_q     <= cfg_data_i[RateW-1:0];
        CfgMoveDist:  move_dist_q <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and profile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      speed_q   <= '0;
      covered_q <= '0;
      tick_q    <= '0;
      braking_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.restart) begin
              speed_q   <= start_vel_q;
              covered_q <= '0;
              tick_q    <= '0;
              braking_q <= 1'b0;
              state_q   <= S_PUSH;
            end else if (!active) begin
              state_q <= S_PUSH;
            end else if (braking_q) begin
              state_q <= S_APPLY;
            end else begin
              cnt_q   <= '0;
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: begin
          cnt_q <= cnt_q + StepCntW'(1);
          if (cnt_q == LastStep) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          speed_q   <= speed_next;
          covered_q <= cov_next;
          if (tick_q != TickMax) begin
            tick_q <= tick_q + TickCountBits'(1);
          end
          if (!braking_q) begin
            braking_q <= brake;
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (push_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_go) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk_i) begin
    if (push_go) begin
      out_vel_q   <= speed_q;
      out_cov_q   <= covered_q;
      out_tick_q  <= ElapsedW'(tick_q);
      out_brake_q <= braking_q;
      out_fin_q   <= !active;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.velocity_now  = out_vel_q;
  assign out_ch.travelled     = out_cov_q;
  assign out_ch.elapsed_ticks = out_tick_q;
  assign out_ch.braking       = out_brake_q;
  assign out_ch.finished      = out_fin_q;

  // checks
  `TVP_ASSERT_IMP(a_brake_from_apply, $rose(braking_q), $past(state_q) == S_APPLY, "braking set outside the step")
  `TVP_ASSERT_IMP(a_tick_monotonic, !$past(in_fire && in_ch.restart), tick_q >= $past(tick_q), "tick count went back without restart")
  `TVP_ASSERT_NEXT(a_calc_length, (state_q == S_CALC) && (cnt_q == LastStep), state_q == S_APPLY, "serial walk did not end on the last bit")
  `TVP_ASSERT_NEXT(a_push_waits, (state_q == S_PUSH) && out_valid_q && !out_ch.ready, state_q == S_PUSH, "output word overwritten while held")

endmodule

/* hdl/tvp_bit_mul.sv */
// shift-add multiplier that emits its product one bit per step, lsb first
// depends on tvp_pkg
module tvp_bit_mul import tvp_pkg::*; (
  input  logic               clk_i,
  input  tvp_ser_ctl_t       ctl_i,
  input  logic [McandW-1:0]  mcand_i,
  input  logic [MplierW-1:0] mplier_i,
  output logic               bit_o
);

  logic [McandW-1:0]  mcand_q;
  logic [McandW-1:0]  acc_q;
  logic [MplierW-1:0] mplier_q;
  logic [McandW:0]    sum;

  // add the multiplicand under the current multiplier bit
  always_comb begin
    sum   = {1'b0, acc_q} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
    bit_o = sum[0];
  end

  // partial product shifts right, one product bit leaves per step
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (ctl_i.step) begin
      acc_q    <= sum[McandW:1];
      mplier_q <= mplier_q >> 1;
    end
  end

endmodule

/* hdl/tvp_serial_cmp.sv */
// bit-serial test of |v^2 - ve^2| >= limit, fed lsb first by the multipliers
// depends on tvp_pkg
module tvp_serial_cmp import tvp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tvp_ser_ctl_t ctl_i,
  input  logic         v_sq_i,
  input  logic         ve_sq_i,
  input  logic         lim_i,
  output logic         brake_o
);

  logic [1:0] br_up_q, br_up_d;
  logic [1:0] br_dn_q, br_dn_d;
  logic [2:0] sum_up, sum_dn;

  // two running borrows: v^2 - ve^2 - lim and ve^2 - v^2 - lim
  always_comb begin
    sum_up  = 3'(ve_sq_i) + 3'(lim_i) + 3'(br_up_q) + 3'(!v_sq_i);
    sum_dn  = 3'(v_sq_i) + 3'(lim_i) + 3'(br_dn_q) + 3'(!ve_sq_i);
    br_up_d = sum_up[2:1];
    br_dn_d = sum_dn[2:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_up_q <= '0;
      br_dn_q <= '0;
    end else if (ctl_i.load) begin
      br_up_q <= '0;
      br_dn_q <= '0;
    end else if (ctl_i.step) begin
      br_up_q <= br_up_d;
      br_dn_q <= br_dn_d;
    end
  end

  // a difference that ends without borrow is non-negative
  assign brake_o = (br_up_q == 2'd0) || (br_dn_q == 2'd0);

endmodule
